@@ design/dsse_pkg.sv @@
// ----------------------------------------------------------------------------
// dsse_pkg
// Shared types and constants for the descending shaker sort engine: the word
// width, the broadcast control that drives the row of sorting cells, and
// the controller states.
// ----------------------------------------------------------------------------
package dsse_pkg;

	localparam int DATA_W = 32;

	// control broadcast from the controller to every cell of the row
	typedef struct packed {
		logic                     load;   // insert the broadcast word
		logic                     shift;  // move every word one cell to the left
		logic signed [DATA_W-1:0] value;  // word being inserted
	} dsse_ctrl_t;

	typedef enum logic {
		ST_FILL,
		ST_DRAIN
	} dsse_state_t;

endpackage

@@ design/dsse_cell.sv @@
// ----------------------------------------------------------------------------
// dsse_cell
// One cell of the sorting row. Holds one word; the row keeps its occupied
// cells in descending order. On insert a cell keeps its word, takes the new
// word or takes its left neighbour's word; on drain it takes its right
// neighbour's word.
// ----------------------------------------------------------------------------
module dsse_cell
	import dsse_pkg::*;
(
	input  logic                     clk,
	input  dsse_ctrl_t               ctrl,
	input  logic                     occupied,
	input  logic                     left_gt,
	input  logic signed [DATA_W-1:0] left_value,
	input  logic signed [DATA_W-1:0] right_value,
	output logic                     gt,
	output logic signed [DATA_W-1:0] value
);

	logic signed [DATA_W-1:0] value_q;

	// an empty cell behaves as minus infinity
	assign gt    = !occupied || (ctrl.value > value_q);
	assign value = value_q;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			if (left_gt) begin
				value_q <= left_value;
			end else if (gt) begin
				value_q <= ctrl.value;
			end
		end else if (ctrl.shift) begin
			value_q <= right_value;
		end
	end

endmodule

@@ design/descending_shaker_sort_engine.sv @@
// ----------------------------------------------------------------------------
// descending_shaker_sort_engine
// Collects signed words into a row of MAX_ELEMENTS sorting cells, then emits
// them largest first, end_of_run marking the smallest.
// ----------------------------------------------------------------------------
// Each word is inserted into its ordered place in the row in the cycle it is
// accepted, so loading runs at one word per cycle with busy low. Words beyond
// MAX_ELEMENTS are dropped. A word with is_last set closes the set: from the
// next cycle the row shifts one word per cycle towards cell 0, and busy stays
// high until every word held has been shifted out. Results come out of an
// output register fed from cell 0, one per cycle, each flagged by
// result_valid for exactly one cycle; the receiver cannot hold them off, and
// a new set may start as soon as busy falls.
module descending_shaker_sort_engine
	import dsse_pkg::*;
#(
	parameter int MAX_ELEMENTS = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic signed [DATA_W-1:0] value,
	input  logic                     is_last,
	output logic                     result_valid,
	output logic signed [DATA_W-1:0] sorted_value,
	output logic                     end_of_run
);

	localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

	dsse_state_t state_q, state_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic             accept;
	logic             room;
	dsse_ctrl_t       ctrl;

	logic                     occ   [MAX_ELEMENTS];
	logic                     gt    [MAX_ELEMENTS];
	logic signed [DATA_W-1:0] cval  [MAX_ELEMENTS];

	logic                     result_valid_q;
	logic signed [DATA_W-1:0] sorted_value_q;
	logic                     end_of_run_q;

	assign accept = start && !busy;
	assign room   = count_q < CNT_W'(MAX_ELEMENTS);

	assign ctrl.load  = accept && room;
	assign ctrl.shift = (state_q == ST_DRAIN);
	assign ctrl.value = value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FILL;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	always_comb begin
		state_d = state_q;
		count_d = count_q;
		busy    = 1'b0;
		unique case (state_q)
			ST_FILL: begin
				if (accept) begin
					if (room) begin
						count_d = count_q + CNT_W'(1);
					end
					if (is_last) begin
						state_d = ST_DRAIN;
					end
				end
			end
			ST_DRAIN: begin
				busy    = 1'b1;
				count_d = count_q - CNT_W'(1);
				if (count_q == CNT_W'(1)) begin
					state_d = ST_FILL;
				end
			end
			default: begin
				state_d = ST_FILL;
			end
		endcase
	end

	// the row of cells, cell 0 holding the largest word
	for (genvar i = 0; i < MAX_ELEMENTS; i++) begin : g_cell
		logic                     lgt;
		logic signed [DATA_W-1:0] lval;
		logic signed [DATA_W-1:0] rval;

		assign occ[i] = CNT_W'(i) < count_q;

		if (i == 0) begin : g_first
			assign lgt  = 1'b0;
			assign lval = '0;
		end else begin : g_mid
			assign lgt  = gt[i-1];
			assign lval = cval[i-1];
		end

		if (i == MAX_ELEMENTS - 1) begin : g_end
			assign rval = '0;
		end else begin : g_inner
			assign rval = cval[i+1];
		end

		dsse_cell u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.occupied    (occ[i]),
			.left_gt     (lgt),
			.left_value  (lval),
			.right_value (rval),
			.gt          (gt[i]),
			.value       (cval[i])
		);
	end

	// output register, one word per drain cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= (state_q == ST_DRAIN);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DRAIN) begin
			sorted_value_q <= cval[0];
			end_of_run_q   <= (count_q == CNT_W'(1));
		end
	end

	assign result_valid = result_valid_q;
	assign sorted_value = sorted_value_q;
	assign end_of_run   = end_of_run_q;

endmodule

@@ tb/sv/dsse_sort_checker.sv @@
// ----------------------------------------------------------------------------
// dsse_sort_checker
// Watches the word and result channels of the descending shaker sort engine,
// keeps its own copy of the collected set, and on each closing word queues
// the set in descending order. Every result is compared with the oldest
// queued word; mismatches and stray results are counted for the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dsse_sort_checker
	import dsse_pkg::*;
#(
	parameter int CAPACITY = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic                     busy,
	input  logic signed [DATA_W-1:0] value,
	input  logic                     is_last,
	input  logic                     result_valid,
	input  logic signed [DATA_W-1:0] sorted_value,
	input  logic                     end_of_run,
	output int                       mismatches,
	output int                       expected_left,
	output int                       results_checked
);

	typedef struct packed {
		logic signed [DATA_W-1:0] word;
		logic                     last_flag;
	} sorted_word_t;

	logic signed [DATA_W-1:0] held_words [CAPACITY];
	int                       held_count;
	sorted_word_t             expected_words [$];

	task automatic report_mismatch(input string what);
		$display("%0t ns: mismatch: %s", $realtime, what);
		mismatches++;
	endtask

	// order the held set largest first and queue it, flagging the smallest
	task automatic queue_sorted_run();
		logic signed [DATA_W-1:0] run [$];
		logic signed [DATA_W-1:0] key;
		int                       j;
		for (int i = 0; i < held_count; i++) begin
			key = held_words[i];
			j = run.size();
			while (j > 0 && run[j-1] < key)
				j--;
			run.insert(j, key);
		end
		foreach (run[k])
			expected_words.push_back('{word: run[k], last_flag: (k == run.size() - 1)});
		held_count = 0;
	endtask

	task automatic take_word();
		// words beyond the capacity are dropped, the closing one included
		if (held_count < CAPACITY) begin
			held_words[held_count] = value;
			held_count++;
		end
		if (is_last)
			queue_sorted_run();
	endtask

	task automatic check_result();
		sorted_word_t want;
		if (expected_words.size() == 0) begin
			report_mismatch($sformatf("unexpected result %0d end_of_run %b",
				sorted_value, end_of_run));
		end else begin
			want = expected_words.pop_front();
			if (sorted_value !== want.word)
				report_mismatch($sformatf("sorted_value %0d, expected %0d",
					sorted_value, want.word));
			if (end_of_run !== want.last_flag)
				report_mismatch($sformatf("end_of_run %b on %0d, expected %b",
					end_of_run, want.word, want.last_flag));
			results_checked++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_words.delete();
			held_count = 0;
			mismatches = 0;
			results_checked = 0;
			expected_left <= 0;
		end else begin
			if (result_valid)
				check_result();
			if (start && !busy)
				take_word();
			expected_left <= expected_words.size();
		end
	end

endmodule

@@ tb/sv/tb_descending_shaker_sort_engine.sv @@
// ----------------------------------------------------------------------------
// tb_descending_shaker_sort_engine
// Regression for the descending shaker sort engine: directed sets on the
// extremes, duplicates and reversed order, then random sets of mixed sizes
// up to and past the store capacity with random gaps between words. A
// separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_descending_shaker_sort_engine;
	import dsse_pkg::*;

	localparam int CAPACITY = 32;
	localparam int RANDOM_WORDS = 300;
	localparam logic signed [DATA_W-1:0] MOST_NEGATIVE = {1'b1, {(DATA_W-1){1'b0}}};
	localparam logic signed [DATA_W-1:0] MOST_POSITIVE = {1'b0, {(DATA_W-1){1'b1}}};

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     start = 1'b0;
	logic signed [DATA_W-1:0] value = '0;
	logic                     is_last = 1'b0;
	logic                     busy;
	logic                     result_valid;
	logic signed [DATA_W-1:0] sorted_value;
	logic                     end_of_run;

	int mismatches;
	int expected_left;
	int results_checked;
	int words_sent = 0;
	int sets_sent = 0;
	int overfull_sets = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	descending_shaker_sort_engine #(
		.MAX_ELEMENTS(CAPACITY)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.value       (value),
		.is_last     (is_last),
		.result_valid(result_valid),
		.sorted_value(sorted_value),
		.end_of_run  (end_of_run)
	);

	dsse_sort_checker #(
		.CAPACITY(CAPACITY)
	) checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.value          (value),
		.is_last        (is_last),
		.result_valid   (result_valid),
		.sorted_value   (sorted_value),
		.end_of_run     (end_of_run),
		.mismatches     (mismatches),
		.expected_left  (expected_left),
		.results_checked(results_checked)
	);

	// full-range and narrow words equally often, narrow ones to force duplicates, some extremes
	function automatic logic signed [DATA_W-1:0] pick_word();
		case ($urandom_range(0, 4))
			0, 1: pick_word = $urandom;
			2, 3: pick_word = $signed($urandom_range(0, 8)) - 4;
			default: begin
				case ($urandom_range(0, 3))
					0: pick_word = MOST_NEGATIVE;
					1: pick_word = MOST_POSITIVE;
					2: pick_word = -1;
					default: pick_word = 0;
				endcase
			end
		endcase
	endfunction

	// called at a rising edge; returns at the edge where the word was taken
	task automatic drive_word(input logic signed [DATA_W-1:0] w, input logic closes,
			input int unsigned gap);
		if (gap != 0) begin
			start <= 1'b0;
			value <= $urandom;
			is_last <= $urandom_range(0, 1);
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		value <= w;
		is_last <= closes;
		do @(posedge clk); while (busy);
		words_sent++;
	endtask

	task automatic drive_set(input logic signed [DATA_W-1:0] words [$]);
		bit burst;
		burst = ($urandom_range(0, 9) < 3);
		foreach (words[i])
			drive_word(words[i], i == words.size() - 1, burst ? 0 : $urandom_range(0, 19));
		sets_sent++;
		if (words.size() > CAPACITY)
			overfull_sets++;
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		@(posedge clk);
		while (expected_left != 0)
			@(posedge clk);
	endtask

	initial begin
		logic signed [DATA_W-1:0] words [$];
		int                       target;
		int                       pick;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single word, extremes, duplicates, ascending input, doubled maximum
		drive_set('{0});
		drive_set('{MOST_NEGATIVE, MOST_POSITIVE, -1, 0, 1, 32'sh4000_0000});
		drive_set('{5, 5, -3, 5, -3});
		drive_set('{1, 2, 3, 4, 5, 6});
		drive_set('{MOST_POSITIVE, MOST_POSITIVE, MOST_NEGATIVE});
		wait_drained();

		target = words_sent + RANDOM_WORDS;
		while (words_sent < target) begin
			pick = $urandom_range(0, 99);
			words.delete();
			if (pick < 60)
				repeat ($urandom_range(1, 8)) words.push_back(pick_word());
			else if (pick < 85)
				repeat ($urandom_range(9, CAPACITY - 1)) words.push_back(pick_word());
			else if (pick < 93)
				repeat (CAPACITY) words.push_back(pick_word());
			else
				repeat ($urandom_range(CAPACITY + 1, CAPACITY + 8)) words.push_back(pick_word());
			drive_set(words);
			if ($urandom_range(0, 9) == 0)
				wait_drained();
		end

		wait_drained();
		repeat (2 * CAPACITY) @(posedge clk);

		$display("%0d words in %0d sets, %0d of them past the store capacity",
			words_sent, sets_sent, overfull_sets);
		$display("%0d sorted words checked, %0d mismatches", results_checked, mismatches);
		if (mismatches == 0)
			$display("descending_shaker_sort_engine regression: pass");
		else
			$display("descending_shaker_sort_engine regression: fail");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("timeout waiting for the sort engine");
		$display("descending_shaker_sort_engine regression: fail");
		$finish;
	end

endmodule

@@ sim.f @@
design/dsse_pkg.sv
design/dsse_cell.sv
design/descending_shaker_sort_engine.sv
tb/sv/dsse_sort_checker.sv
tb/sv/tb_descending_shaker_sort_engine.sv
